### src/rwcp_pkg.sv
// Package for the RIFF/WAVE chunk parser.
// Holds the parse phase type, chunk tags and header constants; depends on nothing.
`default_nettype none

package rwcp_pkg;

	typedef enum logic [2:0] {
		PH_HDR,
		PH_CHUNK,
		PH_BODY,
		PH_FMT,
		PH_DONE,
		PH_BAD
	} phase_t;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	// fmt chunks shorter than this carry no usable format block
	localparam logic [31:0] FMT_MIN   = 32'd16;
	// index of the last byte of the 12-byte file header
	localparam logic [3:0]  HDR_LAST  = 4'd11;
	localparam logic [3:0]  RIFF_LAST = 4'd3;
	localparam logic [3:0]  CHDR_LAST = 4'd7;
	localparam logic [3:0]  TAG_BYTES = 4'd4;

	// fmt body byte positions
	localparam logic [31:0] FMT_STAGE_END = 32'd8;
	localparam logic [31:0] FMT_BITS_LO   = 32'd14;
	localparam logic [31:0] FMT_BITS_HI   = 32'd15;

endpackage

`default_nettype wire

### src/rwcp_if.sv
// Valid/ready channel interfaces for the RIFF/WAVE chunk parser.
// One interface for input bytes, one for parse results; no package dependency.
`default_nettype none

interface rwcp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       final_byte;

	modport source (output valid, output byte_in, output final_byte, input ready);
	modport sink   (input valid, input byte_in, input final_byte, output ready);
endinterface

interface rwcp_out_if;
	logic        valid;
	logic        ready;
	logic        parse_ok;
	logic [15:0] fmt_code;
	logic [15:0] channel_count;
	logic [31:0] rate_hz;
	logic [15:0] sample_bits;
	logic [31:0] data_offset;
	logic [31:0] data_length;

	modport source (
		output valid, output parse_ok, output fmt_code, output channel_count,
		output rate_hz, output sample_bits, output data_offset, output data_length,
		input ready
	);
	modport sink (
		input valid, input parse_ok, input fmt_code, input channel_count,
		input rate_hz, input sample_bits, input data_offset, input data_length,
		output ready
	);
endinterface

`default_nettype wire

### src/riff_wave_chunk_parser_top.sv
// RIFF/WAVE chunk parser, top level.
// Uses rwcp_pkg for phase type and tags, rwcp_if for the byte and result channels.
`default_nettype none

// Streams a WAV file in, one byte per word on byte_ch, with final_byte set on the
// last word. The block checks the RIFF/WAVE header, walks the chunks, captures the
// fmt fields and the data chunk offset and length, and returns one result word on
// result_ch when the final byte has been consumed; the state then clears so the
// next byte starts a new file. A byte is taken every cycle while no final byte is held
// back: the one state-update stage behind the input register handles a whole byte per
// clock. A result word is registered as its final byte leaves the input register, and
// the input stalls only while a final byte waits for the result register to free up.
module riff_wave_chunk_parser_top #(
	parameter int OFFSET_WIDTH = 32
) (
	input  wire            clk,
	input  wire            arst_n,
	rwcp_in_if.sink        byte_ch,
	rwcp_out_if.source     result_ch
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;
	logic       adv_s1;

	// parse state
	rwcp_pkg::phase_t          phase_q, phase_d;
	logic [OFFSET_WIDTH-1:0]   pos_q, pos_d, pos_inc;
	logic [3:0]                idx_q, idx_d;
	logic [31:0]               tag_q, tag_d, tag_sh;
	logic [31:0]               len_q, len_d, len_new;
	logic [32:0]               left_q, left_d, left_dec;
	logic [31:0]               seen_q, seen_d, seen_inc;
	logic [63:0]               stage_q, stage_d;
	logic [15:0]               fmt_tag_q, fmt_tag_d;
	logic [15:0]               chan_q, chan_d;
	logic [15:0]               bits_q, bits_d;
	logic [31:0]               rate_q, rate_d;
	logic [31:0]               doff_q, doff_d;
	logic [31:0]               dlen_q, dlen_d;
	logic                      fmt_found_q, fmt_found_d;
	logic                      data_found_q, data_found_d;
	logic                      data_cur_q, data_cur_d;

	// result register
	logic        out_valid_q;
	logic        ok_q;
	logic [15:0] res_fmt_q, res_chan_q, res_bits_q;
	logic [31:0] res_rate_q, res_doff_q, res_dlen_q;
	logic        hdr_ok;
	logic        ok_d;

	assign adv_s1        = valid_s1 && (!final_s1 || !out_valid_q || result_ch.ready);
	assign byte_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1  <= byte_ch.byte_in;
			final_s1 <= byte_ch.final_byte;
		end
	end

	assign pos_inc  = (pos_q != '1) ? pos_q + OFFSET_WIDTH'(1) : pos_q;
	assign seen_inc = (seen_q != '1) ? seen_q + 32'd1 : seen_q;
	assign tag_sh   = {tag_q[23:0], byte_s1};
	assign left_dec = left_q - 33'd1;

	always_comb begin
		len_new = len_q;
		len_new[8*idx_q[1:0] +: 8] = byte_s1;
	end

	// next-state logic for one byte
	always_comb begin
		phase_d      = phase_q;
		pos_d        = pos_inc;
		idx_d        = idx_q;
		tag_d        = tag_q;
		len_d        = len_q;
		left_d       = left_q;
		seen_d       = seen_q;
		stage_d      = stage_q;
		fmt_tag_d    = fmt_tag_q;
		chan_d       = chan_q;
		bits_d       = bits_q;
		rate_d       = rate_q;
		doff_d       = doff_q;
		dlen_d       = dlen_q;
		fmt_found_d  = fmt_found_q;
		data_found_d = data_found_q;
		data_cur_d   = data_cur_q;

		case (phase_q)
			rwcp_pkg::PH_HDR: begin
				tag_d = tag_sh;
				if (idx_q == rwcp_pkg::RIFF_LAST && tag_sh != rwcp_pkg::TAG_RIFF) begin
					phase_d = rwcp_pkg::PH_BAD;
				end else if (idx_q == rwcp_pkg::HDR_LAST) begin
					phase_d = (tag_sh == rwcp_pkg::TAG_WAVE) ? rwcp_pkg::PH_CHUNK
						: rwcp_pkg::PH_BAD;
					idx_d = '0;
				end else begin
					idx_d = idx_q + 4'd1;
				end
			end
			rwcp_pkg::PH_CHUNK: begin
				if (idx_q < rwcp_pkg::TAG_BYTES) begin
					tag_d = tag_sh;
					if (idx_q == '0) begin
						len_d = '0;
					end
					idx_d = idx_q + 4'd1;
				end else if (idx_q < rwcp_pkg::CHDR_LAST) begin
					len_d = len_new;
					idx_d = idx_q + 4'd1;
				end else begin
					len_d      = len_new;
					idx_d      = '0;
					data_cur_d = 1'b0;
					left_d     = {1'b0, len_new} + {32'd0, len_new[0]};
					seen_d     = '0;
					stage_d    = '0;
					if (len_new == '0) begin
						phase_d = rwcp_pkg::PH_CHUNK;
					end else if (tag_q == rwcp_pkg::TAG_FMT && len_new >= rwcp_pkg::FMT_MIN) begin
						phase_d = rwcp_pkg::PH_FMT;
					end else begin
						phase_d = rwcp_pkg::PH_BODY;
					end
					if (tag_q == rwcp_pkg::TAG_DATA) begin
						doff_d       = 32'(pos_inc);
						dlen_d       = '0;
						data_found_d = 1'b1;
						data_cur_d   = 1'b1;
						// data after a good fmt ends the walk
						if (fmt_found_q) begin
							phase_d = rwcp_pkg::PH_DONE;
						end
					end
				end
			end
			rwcp_pkg::PH_BODY: begin
				if (data_cur_q && dlen_q < len_q) begin
					dlen_d = dlen_q + 32'd1;
				end
				seen_d = seen_inc;
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = rwcp_pkg::PH_CHUNK;
					idx_d   = '0;
				end
			end
			rwcp_pkg::PH_FMT: begin
				if (seen_q < rwcp_pkg::FMT_STAGE_END) begin
					stage_d[8*seen_q[2:0] +: 8] = byte_s1;
				end else if (seen_q == rwcp_pkg::FMT_BITS_LO) begin
					tag_d = {24'd0, byte_s1};
				end else if (seen_q == rwcp_pkg::FMT_BITS_HI) begin
					fmt_tag_d   = stage_q[15:0];
					chan_d      = stage_q[31:16];
					rate_d      = stage_q[63:32];
					bits_d      = {byte_s1, tag_q[7:0]};
					fmt_found_d = 1'b1;
				end
				seen_d = seen_inc;
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = rwcp_pkg::PH_CHUNK;
					idx_d   = '0;
				end
			end
			rwcp_pkg::PH_DONE: begin
				if (data_cur_q && dlen_q < len_q) begin
					dlen_d = dlen_q + 32'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// result fields, taken from the state after the final byte
	always_comb begin
		hdr_ok = phase_d != rwcp_pkg::PH_HDR && phase_d != rwcp_pkg::PH_BAD;
		ok_d   = hdr_ok && fmt_found_d && data_found_d && chan_d != '0 && rate_d != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= rwcp_pkg::PH_HDR;
			pos_q        <= '0;
			idx_q        <= '0;
			tag_q        <= '0;
			len_q        <= '0;
			left_q       <= '0;
			seen_q       <= '0;
			stage_q      <= '0;
			fmt_tag_q    <= '0;
			chan_q       <= '0;
			bits_q       <= '0;
			rate_q       <= '0;
			doff_q       <= '0;
			dlen_q       <= '0;
			fmt_found_q  <= 1'b0;
			data_found_q <= 1'b0;
			data_cur_q   <= 1'b0;
		end else if (adv_s1 && final_s1) begin
			phase_q      <= rwcp_pkg::PH_HDR;
			pos_q        <= '0;
			idx_q        <= '0;
			tag_q        <= '0;
			len_q        <= '0;
			left_q       <= '0;
			seen_q       <= '0;
			stage_q      <= '0;
			fmt_tag_q    <= '0;
			chan_q       <= '0;
			bits_q       <= '0;
			rate_q       <= '0;
			doff_q       <= '0;
			dlen_q       <= '0;
			fmt_found_q  <= 1'b0;
			data_found_q <= 1'b0;
			data_cur_q   <= 1'b0;
		end else if (adv_s1) begin
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			idx_q        <= idx_d;
			tag_q        <= tag_d;
			len_q        <= len_d;
			left_q       <= left_d;
			seen_q       <= seen_d;
			stage_q      <= stage_d;
			fmt_tag_q    <= fmt_tag_d;
			chan_q       <= chan_d;
			bits_q       <= bits_d;
			rate_q       <= rate_d;
			doff_q       <= doff_d;
			dlen_q       <= dlen_d;
			fmt_found_q  <= fmt_found_d;
			data_found_q <= data_found_d;
			data_cur_q   <= data_cur_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && final_s1) begin
			ok_q       <= ok_d;
			res_fmt_q  <= hdr_ok ? fmt_tag_d : '0;
			res_chan_q <= hdr_ok ? chan_d : '0;
			res_rate_q <= hdr_ok ? rate_d : '0;
			res_bits_q <= hdr_ok ? bits_d : '0;
			res_doff_q <= hdr_ok ? doff_d : '0;
			res_dlen_q <= hdr_ok ? dlen_d : '0;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.parse_ok      = ok_q;
	assign result_ch.fmt_code      = res_fmt_q;
	assign result_ch.channel_count = res_chan_q;
	assign result_ch.rate_hz       = res_rate_q;
	assign result_ch.sample_bits   = res_bits_q;
	assign result_ch.data_offset   = res_doff_q;
	assign result_ch.data_length   = res_dlen_q;

	// a body phase always has bytes left to skip
	a_body_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == rwcp_pkg::PH_BODY || phase_q == rwcp_pkg::PH_FMT) |-> left_q != '0)
		else $error("body phase with nothing left to skip");

	// the walk only stops after both fmt and data were seen
	a_done_flags: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == rwcp_pkg::PH_DONE |-> (fmt_found_q && data_found_q && data_cur_q))
		else $error("parse done without fmt and data");

	// a consumed final byte always leaves a result word behind
	a_final_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && final_s1) |=> (out_valid_q && phase_q == rwcp_pkg::PH_HDR))
		else $error("final byte did not produce a result");

endmodule

`default_nettype wire

### tb/riff_wave_chunk_parser_top_tb.sv
// Testbench for riff_wave_chunk_parser_top: streams directed and random WAV files into
// the byte channel; checks each result word against a cycle-free parser model or the
// directed table. Depends on rwcp_pkg and the rwcp_in_if / rwcp_out_if interfaces.
module riff_wave_chunk_parser_top_tb;

	localparam int ITEMS        = 1450;
	localparam int IDLE_PCT     = 25;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_AT      = 700;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;

	localparam int FL_FMT  = 0;
	localparam int FL_DATA = 1;
	localparam int FL_CUR  = 2;

	localparam logic [31:0] TAG_LIST  = 32'h4C49_5354;
	// chunks declared larger than this are cut short when the file is built
	localparam logic [31:0] BIG_CHUNK = 32'd16;

	typedef struct packed {
		logic        parse_ok;
		logic [15:0] fmt_code;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [15:0] sample_bits;
		logic [31:0] data_offset;
		logic [31:0] data_length;
	} file_result_t;

	typedef struct packed {
		logic [7:0]   data;
		logic         last;
		logic         typed;
		file_result_t want;
	} byte_word_t;

	localparam file_result_t NO_INFO   = '0;
	localparam file_result_t BARE_DATA = '{parse_ok: 1'b0, fmt_code: 16'd0,
		channel_count: 16'd0, rate_hz: 32'd0, sample_bits: 16'd0,
		data_offset: 32'd20, data_length: 32'd0};

	localparam int DIR_ROWS = 26;
	localparam byte_word_t DIR_TAB [DIR_ROWS] = '{
		'{8'h00, 1'b1, 1'b1, NO_INFO},		// lone zero byte
		'{8'hFF, 1'b1, 1'b1, NO_INFO},		// lone 0xFF byte
		'{8'h52, 1'b0, 1'b0, NO_INFO},		// "RIFX": bad tag
		'{8'h49, 1'b0, 1'b0, NO_INFO},
		'{8'h46, 1'b0, 1'b0, NO_INFO},
		'{8'h58, 1'b1, 1'b1, NO_INFO},
		'{8'h52, 1'b0, 1'b0, NO_INFO},		// good header, then an empty data chunk, no fmt
		'{8'h49, 1'b0, 1'b0, NO_INFO},
		'{8'h46, 1'b0, 1'b0, NO_INFO},
		'{8'h46, 1'b0, 1'b0, NO_INFO},
		'{8'hFF, 1'b0, 1'b0, NO_INFO},
		'{8'hFF, 1'b0, 1'b0, NO_INFO},
		'{8'hFF, 1'b0, 1'b0, NO_INFO},
		'{8'hFF, 1'b0, 1'b0, NO_INFO},
		'{8'h57, 1'b0, 1'b0, NO_INFO},
		'{8'h41, 1'b0, 1'b0, NO_INFO},
		'{8'h56, 1'b0, 1'b0, NO_INFO},
		'{8'h45, 1'b0, 1'b0, NO_INFO},
		'{8'h64, 1'b0, 1'b0, NO_INFO},
		'{8'h61, 1'b0, 1'b0, NO_INFO},
		'{8'h74, 1'b0, 1'b0, NO_INFO},
		'{8'h61, 1'b0, 1'b0, NO_INFO},
		'{8'h00, 1'b0, 1'b0, NO_INFO},
		'{8'h00, 1'b0, 1'b0, NO_INFO},
		'{8'h00, 1'b0, 1'b0, NO_INFO},
		'{8'h00, 1'b1, 1'b1, BARE_DATA}
	};

	logic clk = 1'b0;
	logic arst_n;

	rwcp_in_if  byte_ch();
	rwcp_out_if result_ch();

	riff_wave_chunk_parser_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	byte_word_t    words_q[$];
	byte_word_t    on_bus;
	file_result_t  pending_info[$];
	logic [7:0]    fb[$];

	int errors         = 0;
	int words_taken    = 0;
	int files_seen     = 0;
	int results_seen   = 0;
	int clean_results  = 0;
	int quiet_cycles   = 0;

	// parser model state
	rwcp_pkg::phase_t ps_phase;
	logic [31:0] ps_pos;
	logic [3:0]  ps_idx;
	logic [31:0] ps_tag;
	logic [31:0] ps_len;
	logic [32:0] ps_left;
	logic [31:0] ps_seen;
	logic [63:0] ps_stage;
	logic [15:0] ps_fmt_tag;
	logic [15:0] ps_chans;
	logic [31:0] ps_rate;
	logic [15:0] ps_bits;
	logic [31:0] ps_off;
	logic [31:0] ps_dlen;
	logic [2:0]  ps_flags;

	task automatic clear_parser();
		ps_phase   = rwcp_pkg::PH_HDR;
		ps_pos     = '0;
		ps_idx     = '0;
		ps_tag     = '0;
		ps_len     = '0;
		ps_left    = '0;
		ps_seen    = '0;
		ps_stage   = '0;
		ps_fmt_tag = '0;
		ps_chans   = '0;
		ps_rate    = '0;
		ps_bits    = '0;
		ps_off     = '0;
		ps_dlen    = '0;
		ps_flags   = '0;
	endtask

	task automatic count_data_byte();
		if (ps_flags[FL_CUR] && ps_dlen < ps_len)
			ps_dlen = ps_dlen + 32'd1;
	endtask

	task automatic finish_body_byte();
		if (ps_seen != '1)
			ps_seen = ps_seen + 32'd1;
		ps_left = ps_left - 33'd1;
		if (ps_left == '0) begin
			ps_phase = rwcp_pkg::PH_CHUNK;
			ps_idx   = '0;
		end
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		logic [31:0] nxt;
		nxt = (ps_pos == '1) ? ps_pos : ps_pos + 32'd1;
		case (ps_phase)
			rwcp_pkg::PH_HDR: begin
				ps_tag = {ps_tag[23:0], b};
				if (ps_idx == rwcp_pkg::RIFF_LAST && ps_tag != rwcp_pkg::TAG_RIFF) begin
					ps_phase = rwcp_pkg::PH_BAD;
				end else if (ps_idx == rwcp_pkg::HDR_LAST) begin
					ps_phase = (ps_tag == rwcp_pkg::TAG_WAVE) ? rwcp_pkg::PH_CHUNK
						: rwcp_pkg::PH_BAD;
					ps_idx   = '0;
				end else begin
					ps_idx = ps_idx + 4'd1;
				end
			end
			rwcp_pkg::PH_CHUNK: begin
				if (ps_idx < rwcp_pkg::TAG_BYTES) begin
					ps_tag = {ps_tag[23:0], b};
					if (ps_idx == '0)
						ps_len = '0;
					ps_idx = ps_idx + 4'd1;
				end else begin
					// size is little endian
					ps_len = ps_len | ({24'd0, b} << (8 * (ps_idx - rwcp_pkg::TAG_BYTES)));
					if (ps_idx < rwcp_pkg::CHDR_LAST) begin
						ps_idx = ps_idx + 4'd1;
					end else begin
						ps_idx   = '0;
						ps_flags[FL_CUR] = 1'b0;
						ps_left  = {1'b0, ps_len} + 33'(ps_len[0]);
						ps_seen  = '0;
						ps_stage = '0;
						if (ps_tag == rwcp_pkg::TAG_DATA) begin
							ps_off  = nxt;
							ps_dlen = '0;
							ps_flags[FL_DATA] = 1'b1;
							ps_flags[FL_CUR]  = 1'b1;
						end
						if (ps_tag == rwcp_pkg::TAG_DATA && ps_flags[FL_FMT])
							ps_phase = rwcp_pkg::PH_DONE;
						else if (ps_left == '0)
							ps_phase = rwcp_pkg::PH_CHUNK;
						else if (ps_tag == rwcp_pkg::TAG_FMT && ps_len >= rwcp_pkg::FMT_MIN)
							ps_phase = rwcp_pkg::PH_FMT;
						else
							ps_phase = rwcp_pkg::PH_BODY;
					end
				end
			end
			rwcp_pkg::PH_BODY: begin
				count_data_byte();
				finish_body_byte();
			end
			rwcp_pkg::PH_FMT: begin
				if (ps_seen < rwcp_pkg::FMT_STAGE_END) begin
					ps_stage = ps_stage | ({56'd0, b} << (8 * ps_seen));
				end else if (ps_seen == rwcp_pkg::FMT_BITS_LO) begin
					ps_tag = {24'd0, b};
				end else if (ps_seen == rwcp_pkg::FMT_BITS_HI) begin
					// 16th byte commits the whole format block
					ps_fmt_tag = ps_stage[15:0];
					ps_chans   = ps_stage[31:16];
					ps_rate    = ps_stage[63:32];
					ps_bits    = {b, ps_tag[7:0]};
					ps_flags[FL_FMT] = 1'b1;
				end
				finish_body_byte();
			end
			rwcp_pkg::PH_DONE: count_data_byte();
			default: ;
		endcase
		ps_pos = nxt;
	endtask

	function automatic file_result_t file_info();
		file_result_t r;
		r = '0;
		if (ps_phase != rwcp_pkg::PH_HDR && ps_phase != rwcp_pkg::PH_BAD) begin
			r.parse_ok      = ps_flags[FL_FMT] && ps_flags[FL_DATA] &&
				ps_chans != '0 && ps_rate != '0;
			r.fmt_code      = ps_fmt_tag;
			r.channel_count = ps_chans;
			r.rate_hz       = ps_rate;
			r.sample_bits   = ps_bits;
			r.data_offset   = ps_off;
			r.data_length   = ps_dlen;
		end
		return r;
	endfunction

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_info(input file_result_t got);
		file_result_t want;
		results_seen++;
		if (got.parse_ok === 1'b1)
			clean_results++;
		if (pending_info.size() == 0) begin
			$display("%0t: result word with no file pending: expected none, got %h", $time, got);
			errors++;
		end else begin
			want = pending_info.pop_front();
			cmp_field("parse_ok", 32'(want.parse_ok), 32'(got.parse_ok));
			cmp_field("fmt_code", 32'(want.fmt_code), 32'(got.fmt_code));
			cmp_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
			cmp_field("rate_hz", want.rate_hz, got.rate_hz);
			cmp_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
			cmp_field("data_offset", want.data_offset, got.data_offset);
			cmp_field("data_length", want.data_length, got.data_length);
		end
	endtask

	// file builders
	task automatic push_word(input logic [7:0] b, input logic last);
		words_q.push_back('{b, last, 1'b0, NO_INFO});
	endtask

	task automatic add_tag(input logic [31:0] t);
		int k;
		for (k = 3; k >= 0; k--)
			fb.push_back(t[8*k +: 8]);
	endtask

	task automatic add_le32(input logic [31:0] v);
		int k;
		for (k = 0; k < 4; k++)
			fb.push_back(v[8*k +: 8]);
	endtask

	task automatic add_random_bytes(input int n);
		int k;
		for (k = 0; k < n; k++)
			fb.push_back(8'($urandom_range(0, 255)));
	endtask

	function automatic logic [31:0] pick_size(input int small_max);
		case ($urandom_range(0, 19))
			0: return '1;
			1: return $urandom();
			default: return 32'($urandom_range(0, small_max));
		endcase
	endfunction

	task automatic add_fmt_chunk();
		logic [31:0] sz;
		logic [7:0]  b;
		bit          no_chans;
		bit          no_rate;
		int          k;
		sz = rwcp_pkg::FMT_MIN;
		case ($urandom_range(0, 9))
			0: sz = 32'd14;
			1: sz = 32'd15;
			2, 3: sz = 32'($urandom_range(17, 23));
			default: ;
		endcase
		no_chans = ($urandom_range(0, 9) == 0);
		no_rate  = ($urandom_range(0, 9) == 0);
		add_tag(rwcp_pkg::TAG_FMT);
		add_le32(sz);
		for (k = 0; k < int'(sz) + int'(sz[0]); k++) begin
			b = 8'($urandom_range(0, 255));
			if ((no_chans && (k == 2 || k == 3)) || (no_rate && k >= 4 && k < 8))
				b = 8'h00;
			fb.push_back(b);
		end
	endtask

	// trailing: bytes after the chunk are ignored, so the body may be short or long
	task automatic add_data_chunk(input bit trailing);
		logic [31:0] sz;
		int          n;
		sz = pick_size(9);
		if (sz > BIG_CHUNK)
			n = $urandom_range(0, 12);
		else if (trailing)
			n = $urandom_range(0, int'(sz) + 4);
		else
			n = int'(sz) + int'(sz[0]);
		add_tag(rwcp_pkg::TAG_DATA);
		add_le32(sz);
		add_random_bytes(n);
	endtask

	task automatic add_other_chunk();
		logic [31:0] sz;
		sz = pick_size(7);
		add_tag($urandom_range(0, 1) ? TAG_LIST : $urandom());
		add_le32(sz);
		add_random_bytes(sz > BIG_CHUNK ? $urandom_range(0, 10) : int'(sz) + int'(sz[0]));
	endtask

	task automatic gen_file();
		int kind;
		int n;
		int keep;
		fb.delete();
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			add_random_bytes($urandom_range(1, 16));
		end else begin
			add_tag(rwcp_pkg::TAG_RIFF);
			add_le32($urandom());
			add_tag(rwcp_pkg::TAG_WAVE);
			if (kind < 22) begin
				n = $urandom_range(0, 11);
				fb[n] = fb[n] ^ (8'h01 << $urandom_range(0, 7));
			end
			if (kind < 75) begin
				if ($urandom_range(0, 3) == 0)
					add_other_chunk();
				add_fmt_chunk();
				if ($urandom_range(0, 3) == 0)
					add_other_chunk();
				add_data_chunk(1'b1);
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) begin
					case ($urandom_range(0, 2))
						0: add_fmt_chunk();
						1: add_data_chunk(1'b0);
						default: add_other_chunk();
					endcase
				end
			end
		end
		// cut the file short somewhere
		if ($urandom_range(0, 99) < 15 && fb.size() > 1) begin
			keep = $urandom_range(1, fb.size() - 1);
			while (fb.size() > keep)
				void'(fb.pop_back());
		end
		foreach (fb[k])
			push_word(fb[k], k == fb.size() - 1);
	endtask

	// sender
	initial begin
		int sent;
		arst_n             = 1'b0;
		byte_ch.valid      = 1'b0;
		byte_ch.byte_in    = 8'h00;
		byte_ch.final_byte = 1'b0;
		on_bus             = '0;
		sent               = 0;
		clear_parser();
		for (int r = 0; r < DIR_ROWS; r++)
			words_q.push_back(DIR_TAB[r]);
		while (words_q.size() < ITEMS)
			gen_file();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (words_q.size() != 0) begin
			@(negedge clk);
			// no idling in this window, so the input backs up during the hold-off
			if ((sent >= 500 && sent < 900) || $urandom_range(0, 99) >= IDLE_PCT) begin
				on_bus = words_q.pop_front();
				byte_ch.valid      <= 1'b1;
				byte_ch.byte_in    <= on_bus.data;
				byte_ch.final_byte <= on_bus.last;
				@(posedge clk);
				while (!byte_ch.ready)
					@(posedge clk);
				sent++;
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (pending_info.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Streamed %0d bytes in %0d files; %0d result words checked, %0d parsed clean.",
			words_taken, files_seen, results_seen, clean_results);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// receiver
	initial begin
		int cyc;
		bit held;
		cyc  = 0;
		held = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (!held && words_taken >= HOLD_AT) begin
				held = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (cyc >= 1300 && cyc < 1800)
				result_ch.ready <= 1'b1;
			else
				result_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// monitor and model
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				check_info('{result_ch.parse_ok, result_ch.fmt_code, result_ch.channel_count,
					result_ch.rate_hz, result_ch.sample_bits, result_ch.data_offset,
					result_ch.data_length});
			if (byte_ch.valid && byte_ch.ready) begin
				words_taken++;
				absorb_byte(byte_ch.byte_in);
				if (byte_ch.final_byte) begin
					files_seen++;
					pending_info.push_back(on_bus.typed ? on_bus.want : file_info());
					clear_parser();
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule

### sim.f
src/rwcp_pkg.sv
src/rwcp_if.sv
src/riff_wave_chunk_parser_top.sv
tb/riff_wave_chunk_parser_top_tb.sv
